@@ rtl/indexed_list_insert_remove_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Concurrent check wrappers, clocked on aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// a condition that must hold at every edge out of reset
`define ILIR_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("indexed list check failed");
// an antecedent that forces a consequent in the next cycle
`define ILIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("indexed list check failed");
`else
`define ILIR_ASSERT_HOLDS(lbl, cond)
`define ILIR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/ilir_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list package
// Field widths, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int POS_W     = 9;
    localparam int VALUE_W   = 32;
    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 9;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;   // position + value, padded to bytes
    localparam int M_TDATA_W = 48;   // data + count, padded to bytes
    localparam int GROUP     = 16;   // fan-in of one readout OR stage

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic             ins;    // insert executes this cycle
        logic             rem;    // remove executes this cycle
        logic             pick;   // drive the addressed word onto readout
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

@@ rtl/ilir_cell.sv @@
// ----------------------------------------------------------------------------
// Indexed list cell
// One list slot: holds a word, shifts up on insert, down on remove.
// ----------------------------------------------------------------------------
module ilir_cell #(
    parameter int WIDTH = 32,
    parameter int IDX   = 0
) (
    input  logic                      aclk,
    input  ilir_pkg::cell_ctrl_t      ctrl_i,
    input  logic [WIDTH-1:0]          value_i,
    input  logic [WIDTH-1:0]          left_i,   // word of slot IDX-1
    input  logic [WIDTH-1:0]          right_i,  // word of slot IDX+1
    output logic [WIDTH-1:0]          word_o,
    output logic [WIDTH-1:0]          pick_o
);

    localparam logic [31:0] IDX_U = 32'(IDX);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;
    logic [31:0]      pos_u;
    logic             at_pos;
    logic             above_pos;

    assign pos_u     = 32'(ctrl_i.pos);
    assign at_pos    = (IDX_U == pos_u);
    assign above_pos = (IDX_U > pos_u);

    always_comb begin
        word_next = word_reg;
        if (ctrl_i.ins) begin
            if (at_pos) begin
                word_next = value_i;
            end else if (above_pos) begin
                word_next = left_i;
            end
        end else if (ctrl_i.rem && (at_pos || above_pos)) begin
            word_next = right_i;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_o = word_reg;
    assign pick_o = (ctrl_i.pick && at_pos) ? word_reg : '0;

endmodule

@@ rtl/ilir_or_stage.sv @@
// ----------------------------------------------------------------------------
// Indexed list readout stage
// ORs groups of sixteen words and registers the group results.
// ----------------------------------------------------------------------------
module ilir_or_stage #(
    parameter  int N_IN  = 256,
    parameter  int WIDTH = 32,
    localparam int N_OUT = (N_IN + ilir_pkg::GROUP - 1) / ilir_pkg::GROUP
) (
    input  logic                        aclk,
    input  logic                        en_i,
    input  logic [N_IN-1:0][WIDTH-1:0]  din_i,
    output logic [N_OUT-1:0][WIDTH-1:0] dout_o
);

    localparam int N_PAD = N_OUT * ilir_pkg::GROUP;

    logic [N_PAD-1:0][WIDTH-1:0] padded;
    logic [N_OUT-1:0][WIDTH-1:0] group_or;
    logic [N_OUT-1:0][WIDTH-1:0] dout_reg;

    for (genvar j = 0; j < N_PAD; j++) begin : g_pad
        if (j < N_IN) begin : g_live
            assign padded[j] = din_i[j];
        end else begin : g_zero
            assign padded[j] = '0;
        end
    end

    always_comb begin
        group_or = '0;
        for (int g = 0; g < N_OUT; g++) begin
            for (int k = 0; k < ilir_pkg::GROUP; k++) begin
                group_or[g] = group_or[g] | padded[g * ilir_pkg::GROUP + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            dout_reg <= group_or;
        end
    end

    assign dout_o = dout_reg;

endmodule

@@ rtl/indexed_list_insert_remove_unit.sv @@
// ----------------------------------------------------------------------------
// Indexed list insert/remove unit
// Ordered list of up to DEPTH words kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the operation (insert,
//   remove, read), s_tdata the position and the word to insert. Each request
//   gives exactly one result on the m_ channel: m_tuser carries the status
//   (done, position out of range, list full), m_tdata the removed or read
//   word and the element count after the operation.
//   Inserts and removes update all cells in parallel at the edge that takes
//   the request. The addressed word leaves the chain through a three-level
//   OR tree (sixteen words per level, two registered levels feeding the
//   output register), so a result passes both registered levels and then
//   the output register. One request is in flight at a time: the block
//   takes no new request while an earlier one is still in the readout tree.
//   A finished result waits in the output register while m_tready is low;
//   the block keeps taking no new request until that result has moved on
//   past the tree, so at most one result waits and one is in the tree.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result; stored words are not cleared and are never read before written.
// ----------------------------------------------------------------------------
`include "indexed_list_insert_remove_unit_assert.svh"

module indexed_list_insert_remove_unit #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ilir_pkg::S_TDATA_W-1:0]   s_tdata,  // [8:0] position, [40:9] value
    input  logic [ilir_pkg::KIND_W-1:0]      s_tuser,  // [1:0] kind
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ilir_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] data, [40:32] count
    output logic [ilir_pkg::STATUS_W-1:0]    m_tuser   // [1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int N1 = (DEPTH + ilir_pkg::GROUP - 1) / ilir_pkg::GROUP;
    localparam int N2 = (N1 + ilir_pkg::GROUP - 1) / ilir_pkg::GROUP;
    localparam int N3 = (N2 + ilir_pkg::GROUP - 1) / ilir_pkg::GROUP;

    // ---- request fields ----
    logic [ilir_pkg::POS_W-1:0]   s_position;
    logic [ilir_pkg::VALUE_W-1:0] s_value;
    logic [63:0]                  value_ext;
    logic [WIDTH-1:0]             value_word;

    assign s_position = s_tdata[ilir_pkg::POS_W-1:0];
    assign s_value    = s_tdata[ilir_pkg::POS_W +: ilir_pkg::VALUE_W];
    assign value_ext  = 64'(s_value);
    assign value_word = value_ext[WIDTH-1:0];

    // ---- control state ----
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          st1_valid_reg;
    logic          st2_valid_reg;
    logic          m_valid_reg;

    logic s_accept;
    logic out_load;

    assign s_tready = !st1_valid_reg && !st2_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = st2_valid_reg && (!m_valid_reg || m_tready);

    // ---- request decode ----
    ilir_pkg::cell_ctrl_t ctrl;
    ilir_pkg::status_t    status_now;
    logic [31:0]          pos32;
    logic [31:0]          n32;
    logic [31:0]          cnt32;

    assign pos32 = 32'(s_position);
    assign n32   = 32'(count_reg);

    always_comb begin
        ctrl       = '0;
        ctrl.pos   = s_position;
        status_now = ilir_pkg::ST_RANGE;
        count_next = count_reg;
        unique case (ilir_pkg::kind_t'(s_tuser))
            ilir_pkg::KIND_INSERT: begin
                if (pos32 <= n32) begin
                    if (n32 == 32'(DEPTH)) begin
                        status_now = ilir_pkg::ST_FULL;
                    end else begin
                        status_now = ilir_pkg::ST_DONE;
                        ctrl.ins   = s_accept;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ilir_pkg::KIND_REMOVE: begin
                if (pos32 < n32) begin
                    status_now = ilir_pkg::ST_DONE;
                    ctrl.rem   = s_accept;
                    ctrl.pick  = s_accept;
                    count_next = count_reg - CW'(1);
                end
            end
            ilir_pkg::KIND_READ: begin
                if (pos32 < n32) begin
                    status_now = ilir_pkg::ST_DONE;
                    ctrl.pick  = s_accept;
                end
            end
            default: begin
                status_now = ilir_pkg::ST_RANGE;
            end
        endcase
    end

    assign cnt32 = 32'(count_next);

    // ---- cell chain ----
    logic [DEPTH-1:0][WIDTH-1:0] cell_word;
    logic [DEPTH-1:0][WIDTH-1:0] cell_pick;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WIDTH-1:0] left_w;
        logic [WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = cell_word[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[i+1];
        end

        ilir_cell #(
            .WIDTH (WIDTH),
            .IDX   (i)
        ) u_cell (
            .aclk    (aclk),
            .ctrl_i  (ctrl),
            .value_i (value_word),
            .left_i  (left_w),
            .right_i (right_w),
            .word_o  (cell_word[i]),
            .pick_o  (cell_pick[i])
        );
    end

    // ---- readout tree: only the addressed cell drives a nonzero word ----
    logic [N1-1:0][WIDTH-1:0] lvl1;
    logic [N2-1:0][WIDTH-1:0] lvl2;
    logic [WIDTH-1:0]         lvl3;
    logic [63:0]              lvl3_ext;

    ilir_or_stage #(
        .N_IN  (DEPTH),
        .WIDTH (WIDTH)
    ) u_or1 (
        .aclk   (aclk),
        .en_i   (s_accept),
        .din_i  (cell_pick),
        .dout_o (lvl1)
    );

    ilir_or_stage #(
        .N_IN  (N1),
        .WIDTH (WIDTH)
    ) u_or2 (
        .aclk   (aclk),
        .en_i   (st1_valid_reg),
        .din_i  (lvl1),
        .dout_o (lvl2)
    );

    // last level folds at most sixteen words into the output register
    always_comb begin
        lvl3 = '0;
        for (int k = 0; k < N2; k++) begin
            lvl3 = lvl3 | lvl2[k];
        end
    end

    assign lvl3_ext = 64'(lvl3);

    // ---- status/count ride alongside the tree ----
    logic [ilir_pkg::STATUS_W-1:0] st1_status_reg;
    logic [ilir_pkg::COUNT_W-1:0]  st1_count_reg;
    logic [ilir_pkg::STATUS_W-1:0] st2_status_reg;
    logic [ilir_pkg::COUNT_W-1:0]  st2_count_reg;
    logic [ilir_pkg::STATUS_W-1:0] m_status_reg;
    logic [ilir_pkg::DATA_W-1:0]   m_data_reg;
    logic [ilir_pkg::COUNT_W-1:0]  m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
            end
            st1_valid_reg <= s_accept;
            if (st1_valid_reg) begin
                st2_valid_reg <= 1'b1;
            end else if (out_load) begin
                st2_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_status_reg <= status_now;
            st1_count_reg  <= cnt32[ilir_pkg::COUNT_W-1:0];
        end
        if (st1_valid_reg) begin
            st2_status_reg <= st1_status_reg;
            st2_count_reg  <= st1_count_reg;
        end
        if (out_load) begin
            m_status_reg <= st2_status_reg;
            m_data_reg   <= lvl3_ext[ilir_pkg::DATA_W-1:0];
            m_count_reg  <= st2_count_reg;
        end
    end

    // ---- result channel ----
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(ilir_pkg::M_TDATA_W - ilir_pkg::DATA_W - ilir_pkg::COUNT_W){1'b0}},
                       m_count_reg, m_data_reg};

    // ---- checks ----
    `ILIR_ASSERT_HOLDS(a_one_in_tree, !(st1_valid_reg && st2_valid_reg) && (N3 == 1))
    `ILIR_ASSERT_HOLDS(a_count_bound, 32'(count_reg) <= 32'(DEPTH))
    `ILIR_ASSERT_NEXT(a_accept_enters, s_accept, st1_valid_reg && !s_tready)
    `ILIR_ASSERT_NEXT(a_insert_grows, ctrl.ins, 32'(count_reg) == 32'($past(count_reg)) + 32'd1)

endmodule
